### rtl/tatc_pkg.sv
// Shared types, ROM contents and widths for the thermistor temperature core.
// No dependencies.
package tatc_pkg;

    localparam int RowCount = 51;
    localparam int RowW     = 6;
    localparam int ResW     = 28;
    localparam int AdcW     = 12;
    localparam int SerW     = 16;
    localparam int TempW    = 7;
    localparam int BoundW   = 14;
    localparam int CfgIdxW  = 1;

    localparam logic [CfgIdxW-1:0] CFG_SERIES = 1'd0;
    localparam logic [CfgIdxW-1:0] CFG_SUPPLY = 1'd1;

    typedef struct packed {
        logic [TempW-1:0]  temp;
        logic [BoundW-1:0] lo;
        logic [BoundW-1:0] hi;
    } row_t;

    typedef struct packed {
        logic start;
        logic zero_in;
        logic clamp;
    } cmd_t;

    typedef struct packed {
        logic div_done;
        logic scan_done;
    } sts_t;

    function automatic row_t rom_row(input logic [RowW-1:0] i);
        row_t r;
        case (i)
            6'd0:  r = '{7'd20, 14'd12351, 14'd12657};
            6'd1:  r = '{7'd21, 14'd11811, 14'd12092};
            6'd2:  r = '{7'd22, 14'd11296, 14'd11555};
            6'd3:  r = '{7'd23, 14'd10808, 14'd11045};
            6'd4:  r = '{7'd24, 14'd10342, 14'd10561};
            6'd5:  r = '{7'd25, 14'd9900,  14'd10100};
            6'd6:  r = '{7'd26, 14'd9537,  14'd9784};
            6'd7:  r = '{7'd27, 14'd9223,  14'd9434};
            6'd8:  r = '{7'd28, 14'd8948,  14'd9163};
            6'd9:  r = '{7'd29, 14'd8698,  14'd8897};
            6'd10: r = '{7'd30, 14'd7952,  14'd8147};
            6'd11: r = '{7'd31, 14'd7542,  14'd7707};
            6'd12: r = '{7'd32, 14'd7191,  14'd7346};
            6'd13: r = '{7'd33, 14'd6890,  14'd7044};
            6'd14: r = '{7'd34, 14'd6627,  14'd6781};
            6'd15: r = '{7'd35, 14'd6427,  14'd6613};
            6'd16: r = '{7'd36, 14'd6277,  14'd6562};
            6'd17: r = '{7'd37, 14'd6171,  14'd6457};
            6'd18: r = '{7'd38, 14'd6096,  14'd6385};
            6'd19: r = '{7'd39, 14'd6058,  14'd6338};
            6'd20: r = '{7'd40, 14'd5226,  14'd5400};
            6'd21: r = '{7'd41, 14'd4940,  14'd5102};
            6'd22: r = '{7'd42, 14'd4683,  14'd4840};
            6'd23: r = '{7'd43, 14'd4459,  14'd4614};
            6'd24: r = '{7'd44, 14'd4261,  14'd4415};
            6'd25: r = '{7'd45, 14'd4274,  14'd4434};
            6'd26: r = '{7'd46, 14'd4012,  14'd4163};
            6'd27: r = '{7'd47, 14'd3777,  14'd3918};
            6'd28: r = '{7'd48, 14'd3557,  14'd3691};
            6'd29: r = '{7'd49, 14'd3352,  14'd3481};
            6'd30: r = '{7'd50, 14'd3516,  14'd3661};
            6'd31: r = '{7'd51, 14'd3298,  14'd3437};
            6'd32: r = '{7'd52, 14'd3098,  14'd3237};
            6'd33: r = '{7'd53, 14'd2915,  14'd3046};
            6'd34: r = '{7'd54, 14'd2746,  14'd2875};
            6'd35: r = '{7'd55, 14'd2908,  14'd3039};
            6'd36: r = '{7'd56, 14'd2736,  14'd2858};
            6'd37: r = '{7'd57, 14'd2582,  14'd2698};
            6'd38: r = '{7'd58, 14'd2439,  14'd2552};
            6'd39: r = '{7'd59, 14'd2309,  14'd2419};
            6'd40: r = '{7'd60, 14'd2417,  14'd2535};
            6'd41: r = '{7'd61, 14'd2286,  14'd2401};
            6'd42: r = '{7'd62, 14'd2165,  14'd2280};
            6'd43: r = '{7'd63, 14'd2051,  14'd2165};
            6'd44: r = '{7'd64, 14'd1943,  14'd2053};
            6'd45: r = '{7'd65, 14'd2019,  14'd2126};
            6'd46: r = '{7'd66, 14'd1906,  14'd2008};
            6'd47: r = '{7'd67, 14'd1805,  14'd1901};
            6'd48: r = '{7'd68, 14'd1710,  14'd1802};
            6'd49: r = '{7'd69, 14'd1620,  14'd1710};
            default: r = '{7'd70, 14'd1695, 14'd1790};
        endcase
        return r;
    endfunction

endpackage

### rtl/tatc_datapath.sv
// Datapath: multiply, restoring divider and ROM scan for the temperature core.
// Depends on tatc_pkg.
module tatc_datapath import tatc_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  cmd_t              cmd,
    input  logic [AdcW-1:0]   adc_mv,
    input  logic [SerW-1:0]   series,
    input  logic [AdcW-1:0]   supply,
    output sts_t              sts,
    output logic [TempW-1:0]  temp_out,
    output logic              exact_out,
    output logic              open_out,
    output logic [ResW-1:0]   res_out
);

    typedef enum logic [1:0] {P_IDLE, P_DIV, P_SCAN} phase_t;

    phase_t             phase_reg;
    logic [ResW-1:0]    quo_reg;
    logic [AdcW:0]      rem_reg;
    logic [AdcW-1:0]    den_reg;
    logic [4:0]         cnt_reg;
    logic [RowW-1:0]    row_reg;
    logic [ResW-1:0]    res_reg;
    logic [ResW-1:0]    best_d_reg;
    logic [TempW-1:0]   best_t_reg;
    logic               exact_reg;
    logic               open_reg;
    logic               div_done_reg;
    logic               scan_done_reg;

    logic [ResW-1:0]    prod;
    logic [AdcW:0]      trial;
    logic [AdcW:0]      trial_sub;
    row_t               row;
    logic [ResW-1:0]    lo_w, hi_w, dl, dh, d;
    logic               hit;

    assign prod = ResW'(series) * ResW'(supply - adc_mv);
    assign trial = {rem_reg[AdcW-1:0], quo_reg[ResW-1]};
    assign trial_sub = trial - {1'b0, den_reg};
    assign row = rom_row(row_reg);
    assign lo_w = ResW'(row.lo);
    assign hi_w = ResW'(row.hi);
    assign dl = (res_reg >= lo_w) ? res_reg - lo_w : lo_w - res_reg;
    assign dh = (res_reg >= hi_w) ? res_reg - hi_w : hi_w - res_reg;
    assign d = (dl < dh) ? dl : dh;
    assign hit = (res_reg >= lo_w) && (res_reg <= hi_w);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= P_IDLE;
            div_done_reg  <= 1'b0;
            scan_done_reg <= 1'b0;
        end else begin
            div_done_reg  <= 1'b0;
            scan_done_reg <= 1'b0;
            case (phase_reg)
                P_IDLE: begin
                    if (cmd.start) begin
                        open_reg  <= cmd.zero_in;
                        exact_reg <= 1'b0;
                        row_reg   <= '0;
                        quo_reg   <= prod;
                        rem_reg   <= '0;
                        den_reg   <= adc_mv;
                        cnt_reg   <= '0;
                        if (cmd.zero_in) begin
                            res_reg       <= '1;
                            best_t_reg    <= rom_row('0).temp;
                            scan_done_reg <= 1'b1;
                        end else if (cmd.clamp) begin
                            res_reg      <= '0;
                            div_done_reg <= 1'b1;
                            phase_reg    <= P_SCAN;
                        end else begin
                            phase_reg <= P_DIV;
                        end
                    end
                end
                P_DIV: begin
                    if (!trial_sub[AdcW]) begin
                        rem_reg <= trial_sub;
                        quo_reg <= {quo_reg[ResW-2:0], 1'b1};
                    end else begin
                        rem_reg <= trial;
                        quo_reg <= {quo_reg[ResW-2:0], 1'b0};
                    end
                    cnt_reg <= cnt_reg + 5'd1;
                    if (cnt_reg == 5'(ResW - 1)) begin
                        div_done_reg <= 1'b1;
                        phase_reg    <= P_SCAN;
                        res_reg      <= {quo_reg[ResW-2:0], ~trial_sub[AdcW]};
                    end
                end
                P_SCAN: begin
                    if (row_reg == '0) begin
                        best_d_reg <= (res_reg >= lo_w) ? res_reg - lo_w : lo_w - res_reg;
                        best_t_reg <= row.temp;
                    end
                    if (hit) begin
                        best_t_reg    <= row.temp;
                        exact_reg     <= 1'b1;
                        scan_done_reg <= 1'b1;
                        phase_reg     <= P_IDLE;
                    end else begin
                        if (row_reg == '0 ? (d < dl) : (d < best_d_reg)) begin
                            best_d_reg <= d;
                            best_t_reg <= row.temp;
                        end
                        row_reg <= row_reg + 6'd1;
                        if (row_reg == RowW'(RowCount - 1)) begin
                            scan_done_reg <= 1'b1;
                            phase_reg     <= P_IDLE;
                        end
                    end
                end
                default: phase_reg <= P_IDLE;
            endcase
        end
    end

    assign sts = '{div_done: div_done_reg, scan_done: scan_done_reg};
    assign temp_out  = best_t_reg;
    assign exact_out = exact_reg;
    assign open_out  = open_reg;
    assign res_out   = res_reg;

endmodule

### rtl/tatc_ctrl.sv
// Controller: input handshake, sequencing of the datapath and output handshake.
// Depends on tatc_pkg.
module tatc_ctrl import tatc_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [AdcW-1:0]   adc_mv,
    input  logic [AdcW-1:0]   supply,
    output cmd_t              cmd,
    input  sts_t              sts,
    output logic              busy,
    output logic              load_out,
    input  logic              m_tready,
    output logic              m_tvalid
);

    typedef enum logic [1:0] {S_IDLE, S_RUN, S_OUT} state_t;

    state_t state_reg;
    logic   take;

    assign s_tready = (state_reg == S_IDLE);
    assign take = s_tvalid && s_tready;
    assign cmd = '{start: take, zero_in: (adc_mv == '0), clamp: (adc_mv >= supply)};
    assign busy = (state_reg != S_IDLE);
    assign load_out = sts.scan_done;
    assign m_tvalid = (state_reg == S_OUT);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            case (state_reg)
                S_IDLE: if (take) state_reg <= S_RUN;
                S_RUN:  if (sts.scan_done) state_reg <= S_OUT;
                S_OUT:  if (m_tready) state_reg <= S_IDLE;
                default: state_reg <= S_IDLE;
            endcase
        end
    end

endmodule

### rtl/thermistor_adc_to_temperature_core.sv
// Top level of the thermistor reading to temperature core.
// Depends on tatc_pkg, tatc_ctrl and tatc_datapath.
//
// channel   direction  payload
// s_        in         tdata[11:0] adc_mv
// m_        out        tdata[6:0] temperature_c, [7] exact_match, [8] open_input,
//                      [36:9] resistance_ohms
// cfg_      in         index 0 series_resistance_ohms, 1 supply_mv
//
// One item at a time. m_tvalid rises after the input transfer once the datapath is
// done: a zero reading skips the divider and the scan, a clamped reading skips only
// the divider, any other reading is divided and then scanned (the scan stops early on an exact match).
// The result holds until transferred; s_tready returns the cycle after that.
// Reset is synchronous, active low.
module thermistor_adc_to_temperature_core import tatc_pkg::*; (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [15:0]         s_tdata,   // adc_mv
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [39:0]         m_tdata,   // temperature_c, exact_match, open_input, resistance
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [CfgIdxW-1:0]  cfg_index,
    input  logic [15:0]         cfg_data
);

    logic [SerW-1:0]  series_reg;
    logic [AdcW-1:0]  supply_reg;
    cmd_t             cmd;
    sts_t             sts;
    logic             busy, load_out;
    logic [TempW-1:0] temp_w;
    logic             exact_w, open_w;
    logic [ResW-1:0]  res_w;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            series_reg <= SerW'(10000);
            supply_reg <= AdcW'(3300);
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_SERIES: series_reg <= cfg_data;
                CFG_SUPPLY: supply_reg <= cfg_data[AdcW-1:0];
                default: ;
            endcase
        end
    end

    tatc_ctrl u_ctrl (
        .aclk, .aresetn, .s_tvalid, .s_tready,
        .adc_mv(s_tdata[AdcW-1:0]), .supply(supply_reg),
        .cmd, .sts, .busy, .load_out, .m_tready, .m_tvalid
    );

    tatc_datapath u_dp (
        .aclk, .aresetn, .cmd, .adc_mv(s_tdata[AdcW-1:0]),
        .series(series_reg), .supply(supply_reg), .sts,
        .temp_out(temp_w), .exact_out(exact_w), .open_out(open_w), .res_out(res_w)
    );

    assign m_tdata = {3'b000, res_w, open_w, exact_w, temp_w};

    a_out_after_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        load_out |=> m_tvalid) else $error("result not presented after scan");
    a_no_take_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        busy |-> !s_tready) else $error("input taken while busy");
    a_open_no_exact: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && open_w |-> !exact_w) else $error("open input flagged exact");

endmodule
